// ===== hw/rtl/mlfq_pkg.sv =====
// Package: shared types, codes and constants of the MLFQ scheduler.
package mlfq_pkg;

  localparam int unsigned SLOTS     = 16;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned LINK_W    = 5;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CNT_W     = 5;
  localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

  localparam logic [15:0] AGING_RST = 16'd1000;
  localparam logic [9:0]  SCAN_RST  = 10'd50;

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_SLEEP = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic {
    CFG_AGING = 1'b0,
    CFG_SCAN  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [SLOT_W-1:0] thread_id;
    logic [1:0]        priority_req;
    logic [TIME_W-1:0] wake_time;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] picked_thread;
    logic              picked_valid;
    logic              ready_empty;
    logic              sleep_empty;
    logic [CNT_W-1:0]  woken_count;
    logic [CNT_W-1:0]  promoted_count;
    logic              rejected;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WSCAN,
    ST_ACHECK,
    ST_AWALK,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic exec;       // enqueue / dequeue / sleep / tick time bump
    logic wscan;      // one wake scan step
    logic acheck;     // interval check, clear scan flags
    logic astart;     // latch last scan time, start walk of level 1
    logic awalk;      // one aging walk step
    logic emit;       // drive result
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic wake_found;
    logic scan_due;
    logic walk_done;
  } sts_t;

endpackage

// ===== hw/rtl/mlfq_scheduler_with_aging_unit.sv =====
// Top level: three-level feedback queue scheduler with sleep set and aging.
// Flow: enqueue, dequeue and sleep pass through execute to the result beat. A tick
// then runs wake scan passes over all 16 slots, one waking per pass, until a pass
// wakes none, plus, when an aging scan is due, an aging walk of levels 1 and 2.
// One command at a time; busy is high until the result strobe. Receiver cannot stall.
// Synchronous active-low reset empties all levels and the sleep set, clears time.
module mlfq_scheduler_with_aging_unit import mlfq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready = 1'b1;

  mlfq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  mlfq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/mlfq_ctrl.sv =====
// Controller: sequences one command through execute, wake scan and aging walk.
module mlfq_ctrl import mlfq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.exec  = 1'b1;
        state_nxt = sts.is_tick ? ST_WSCAN : ST_DONE;
      end
      ST_WSCAN: begin
        ctl.wscan = 1'b1;
        if (!sts.wake_found) state_nxt = ST_ACHECK;
      end
      ST_ACHECK: begin
        ctl.acheck = 1'b1;
        if (sts.scan_due) begin
          ctl.astart = 1'b1;
          state_nxt  = ST_AWALK;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_AWALK: begin
        ctl.awalk = 1'b1;
        if (sts.walk_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        ctl.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/mlfq_dp.sv =====
// Datapath: level lists, sleep set, time keeping and result register.
module mlfq_dp import mlfq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  input  ctl_t              ctl,
  output sts_t              sts,
  output logic              out_valid,
  output out_item_t         out_data
);

  logic [LINK_W-1:0] head_r [3];
  logic [LINK_W-1:0] tail_r [3];
  logic [LINK_W-1:0] link_r [SLOTS];
  logic [TIME_W-1:0] stamp_r [SLOTS];
  logic [TIME_W-1:0] wake_r [SLOTS];
  logic [1:0]        wlvl_r [SLOTS];
  logic [SLOTS-1:0]  sleep_r, queued_r, pmark_r;
  logic [TIME_W-1:0] now_r, last_r;
  logic [15:0]       thr_r;
  logic [9:0]        ivl_r;
  in_item_t          item_r;
  logic [CNT_W-1:0]  woken_r, prom_r;
  logic [SLOT_W-1:0] pick_r;
  logic              pvalid_r, rej_r;
  logic              due_r;
  // aging walk state
  logic              wlev_r;      // 0: level 1, 1: level 2
  logic [LINK_W-1:0] prev_r, cur_r;
  // wake scan state
  logic [SLOT_W-1:0] sidx_r;
  logic              sbest_v_r;
  logic [SLOT_W-1:0] sbest_r;
  logic              svalid_r;
  out_item_t         out_r;
  logic              ov_r;

  logic [1:0] lvl;
  assign lvl = (item_r.priority_req == 2'd3) ? 2'd2 : item_r.priority_req;

  logic busy_slot;
  assign busy_slot = queued_r[item_r.thread_id] | sleep_r[item_r.thread_id];

  // wake scan: one slot per cycle, then commit best at wrap
  logic cand;
  assign cand = sleep_r[sidx_r] && (wake_r[sidx_r] <= now_r) &&
                (!sbest_v_r || (wake_r[sidx_r] < wake_r[sbest_r]));
  logic scan_last;
  assign scan_last = (sidx_r == SLOT_W'(SLOTS-1));
  logic [SLOT_W-1:0] win;
  logic              win_v;
  assign win_v = cand | sbest_v_r;
  assign win   = cand ? sidx_r : sbest_r;

  // aging walk
  logic [1:0]        plev;
  logic [SLOT_W-1:0] cs;
  logic              cur_nil, age_hit;
  logic [TIME_W-1:0] elapsed;
  assign plev    = wlev_r ? 2'd2 : 2'd1;
  assign cur_nil = cur_r[LINK_W-1];
  assign cs      = cur_r[SLOT_W-1:0];
  assign elapsed = now_r - stamp_r[cs];
  assign age_hit = !cur_nil && (elapsed >= TIME_W'(thr_r)) && (stamp_r[cs] != '0);

  // keep scanning until a full pass finds no due sleeper
  assign sts.is_tick    = (item_r.operation == OP_TICK);
  assign sts.wake_found = !(svalid_r && scan_last && !win_v);
  assign sts.scan_due   = due_r;
  assign sts.walk_done  = cur_nil && wlev_r;

  logic [TIME_W-1:0] since;
  assign since = now_r - last_r;

  logic [LINK_W-1:0] app_slot;
  logic [1:0]        app_lvl;
  logic              app_en;
  logic [LINK_W-1:0] nxt_l;
  assign nxt_l = link_r[cs];

  always_comb begin
    app_en   = 1'b0;
    app_slot = '0;
    app_lvl  = 2'd0;
    if (ctl.exec && item_r.operation == OP_ENQ && !busy_slot) begin
      app_en = 1'b1; app_slot = {1'b0, item_r.thread_id}; app_lvl = lvl;
    end else if (ctl.wscan && scan_last && win_v && svalid_r) begin
      app_en = 1'b1; app_slot = {1'b0, win}; app_lvl = wlvl_r[win];
    end else if (ctl.awalk && age_hit) begin
      app_en = 1'b1; app_slot = cur_r; app_lvl = 2'd0;
    end
  end

  logic [CNT_W-1:0] woken_inc, prom_inc;
  assign woken_inc = (woken_r == 5'd31) ? woken_r : woken_r + 5'd1;
  assign prom_inc  = (prom_r == 5'd31) ? prom_r : prom_r + 5'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        head_r[i] <= NIL;
        tail_r[i] <= NIL;
      end
      for (int i = 0; i < SLOTS; i++) begin
        link_r[i] <= NIL;
        wlvl_r[i] <= 2'd0;
      end
      sleep_r <= '0; queued_r <= '0; pmark_r <= '0;
      now_r <= '0; last_r <= '0;
      thr_r <= AGING_RST; ivl_r <= SCAN_RST;
      ov_r <= 1'b0; svalid_r <= 1'b0;
      sbest_v_r <= 1'b0; sidx_r <= '0; due_r <= 1'b0;
      wlev_r <= 1'b0; prev_r <= NIL; cur_r <= NIL;
    end else begin
      ov_r <= ctl.emit;
      if (cfg_we) begin
        if (cfg_index == CFG_AGING) thr_r <= cfg_data[15:0];
        else                        ivl_r <= cfg_data[9:0];
      end
      if (ctl.load) begin
        item_r   <= in_data;
        woken_r  <= '0; prom_r <= '0;
        pick_r   <= '0; pvalid_r <= 1'b0; rej_r <= 1'b0;
      end
      if (ctl.exec) begin
        unique case (item_r.operation)
          OP_ENQ, OP_SLEEP: begin
            if (busy_slot) rej_r <= 1'b1;
            else if (item_r.operation == OP_SLEEP) begin
              sleep_r[item_r.thread_id] <= 1'b1;
              wake_r[item_r.thread_id]  <= item_r.wake_time;
              wlvl_r[item_r.thread_id]  <= lvl;
            end
          end
          OP_DEQ: begin
            for (int p = 2; p >= 0; p--) begin
              if (!head_r[p][LINK_W-1]) begin
                pick_r   <= head_r[p][SLOT_W-1:0];
                pvalid_r <= 1'b1;
              end
            end
          end
          OP_TICK: begin
            now_r     <= now_r + 1'b1;
            sidx_r    <= '0;
            sbest_v_r <= 1'b0;
            svalid_r  <= 1'b1;
          end
          default: ;
        endcase
        // dequeue pop
        if (item_r.operation == OP_DEQ) begin
          if (!head_r[0][LINK_W-1]) begin
            head_r[0] <= link_r[head_r[0][SLOT_W-1:0]];
            if (link_r[head_r[0][SLOT_W-1:0]] == NIL) tail_r[0] <= NIL;
            queued_r[head_r[0][SLOT_W-1:0]] <= 1'b0;
          end else if (!head_r[1][LINK_W-1]) begin
            head_r[1] <= link_r[head_r[1][SLOT_W-1:0]];
            if (link_r[head_r[1][SLOT_W-1:0]] == NIL) tail_r[1] <= NIL;
            queued_r[head_r[1][SLOT_W-1:0]] <= 1'b0;
          end else if (!head_r[2][LINK_W-1]) begin
            head_r[2] <= link_r[head_r[2][SLOT_W-1:0]];
            if (link_r[head_r[2][SLOT_W-1:0]] == NIL) tail_r[2] <= NIL;
            queued_r[head_r[2][SLOT_W-1:0]] <= 1'b0;
          end
        end
      end
      if (ctl.wscan) begin
        if (scan_last) begin
          if (win_v) begin
            sleep_r[win] <= 1'b0;
            woken_r      <= woken_inc;
          end else begin
            svalid_r <= 1'b0;
          end
          sidx_r    <= '0;
          sbest_v_r <= 1'b0;
        end else begin
          sidx_r    <= sidx_r + 1'b1;
          sbest_v_r <= win_v;
          sbest_r   <= win;
        end
      end
      if (ctl.acheck) begin
        svalid_r <= 1'b0;
        due_r    <= 1'b0;
      end
      if (ctl.astart) begin
        last_r <= now_r;
        wlev_r <= 1'b0;
        prev_r <= NIL;
        cur_r  <= head_r[1];
      end
      if (ctl.awalk) begin
        if (cur_nil) begin
          wlev_r <= 1'b1;
          prev_r <= NIL;
          cur_r  <= head_r[2];
        end else begin
          if (age_hit) begin
            if (prev_r == NIL) head_r[plev] <= nxt_l;
            else               link_r[prev_r[SLOT_W-1:0]] <= nxt_l;
            if (tail_r[plev] == cur_r) tail_r[plev] <= prev_r;
            pmark_r[cs] <= 1'b1;
            prom_r      <= prom_inc;
          end else begin
            prev_r <= cur_r;
          end
          cur_r <= nxt_l;
        end
      end
      // append last: its writes override unlink updates where both land
      if (app_en) begin
        link_r[app_slot[SLOT_W-1:0]]  <= NIL;
        stamp_r[app_slot[SLOT_W-1:0]] <= now_r;
        queued_r[app_slot[SLOT_W-1:0]] <= 1'b1;
        if (tail_r[app_lvl] == NIL || (ctl.awalk && tail_r[app_lvl] == cur_r &&
            app_lvl == plev)) begin
          head_r[app_lvl] <= app_slot;
        end else begin
          link_r[tail_r[app_lvl][SLOT_W-1:0]] <= app_slot;
        end
        tail_r[app_lvl] <= app_slot;
      end
      // due flag computed before acheck
      if (ctl.wscan) due_r <= (since >= TIME_W'(ivl_r));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_r.picked_thread  <= pick_r;
      out_r.picked_valid   <= pvalid_r;
      out_r.ready_empty    <= head_r[0][LINK_W-1] & head_r[1][LINK_W-1] & head_r[2][LINK_W-1];
      out_r.sleep_empty    <= (sleep_r == '0);
      out_r.woken_count    <= woken_r;
      out_r.promoted_count <= prom_r;
      out_r.rejected       <= rej_r;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule
